FILE: design/frfr_pkg.sv
// ----------------------------------------------------------------------------
// frfr_pkg
// Shared types and constants of the frame rotate/flip reader: request and
// result payloads, register indexes, command and rotation codes.
// ----------------------------------------------------------------------------
package frfr_pkg;

  // Default store dimensions (entries per row, rows).
  localparam int MaxWidthDef  = 512;
  localparam int MaxHeightDef = 512;

  // Frame size registers and all coordinates inside the block.
  localparam int SizeW    = 10;
  localparam int CoordW   = SizeW;
  localparam int InCoordW = 9;
  localparam int ByteW    = 8;
  localparam int PixW     = 4 * ByteW;

  // Configuration port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 10;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_ROTATION     = 3'd2,
    REG_MIRROR_H     = 3'd3,
    REG_MIRROR_V     = 3'd4
  } cfg_idx_e;

  typedef enum logic [0:0] {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ROT_NONE = 2'd0,
    ROT_90   = 2'd1,
    ROT_270  = 2'd2
  } rot_e;

  typedef struct packed {
    logic                cmd;
    logic [InCoordW-1:0] col;
    logic [InCoordW-1:0] row;
    logic [ByteW-1:0]    blue_in;
    logic [ByteW-1:0]    green_in;
    logic [ByteW-1:0]    red_in;
    logic [ByteW-1:0]    alpha_in;
  } in_req_t;

  typedef struct packed {
    logic [ByteW-1:0] red_out;
    logic [ByteW-1:0] green_out;
    logic [ByteW-1:0] blue_out;
    logic [ByteW-1:0] alpha_out;
    logic             out_of_range;
  } result_t;

  // Access to the pixel store: one write or one read per cycle.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [PixW-1:0]   wdata;
  } store_req_t;

endpackage

FILE: design/frfr_store.sv
// ----------------------------------------------------------------------------
// frfr_store
// Pixel store of MAX_HEIGHT rows by MAX_WIDTH entries, one write or read
// port access per cycle, read data registered.
// ----------------------------------------------------------------------------
module frfr_store #(
  parameter int MAX_WIDTH  = frfr_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = frfr_pkg::MaxHeightDef
) (
  input  logic                      clk_i,
  input  frfr_pkg::store_req_t      req_i,
  output logic [frfr_pkg::PixW-1:0] rdata_o
);

  localparam int XIdxW = $clog2(MAX_WIDTH);
  localparam int YIdxW = $clog2(MAX_HEIGHT);

  logic [frfr_pkg::PixW-1:0] mem_q [MAX_HEIGHT][MAX_WIDTH];
  logic [frfr_pkg::PixW-1:0] rdata_q;
  logic [XIdxW-1:0]          x_idx;
  logic [YIdxW-1:0]          y_idx;

  // Coordinates handed in are always inside the store.
  assign x_idx = XIdxW'(req_i.x);
  assign y_idx = YIdxW'(req_i.y);

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[y_idx][x_idx] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[y_idx][x_idx];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/frame_rotate_flip_reader_unit.sv
// ----------------------------------------------------------------------------
// frame_rotate_flip_reader_unit
// Frame store with a read port that applies a 0/90/270 degree rotation and
// optional horizontal and vertical mirroring.
// ----------------------------------------------------------------------------
// Usage: a request is taken at a rising edge with start high and busy low.
// busy is never raised, so a request may be issued on every cycle. A write
// request (cmd = 0) stores one BGRA pixel at its source column and row and
// gives no result; writes outside the configured frame size are dropped.
// A read request (cmd = 1) names an output coordinate; the pixel then
// sits on result_o for exactly one cycle, flagged by result_strobe_o.
// A read outside the output size returns a zero pixel with out_of_range
// set. The throughput is one request per cycle, set by the single port of
// the pixel store; a read passes the address register, then the registered
// read of the store. The receiver cannot hold results off, so nothing ever
// waits. Reset clears the pipeline and sets the registers to a 512 by 512
// frame, no rotation, no mirroring. The store content is undefined after
// reset and must be written before read. Registers must be written by the
// user through cfg_we_i only while no request is in flight; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module frame_rotate_flip_reader_unit #(
  parameter int MAX_WIDTH  = frfr_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = frfr_pkg::MaxHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  frfr_pkg::in_req_t             req_i,
  output logic                          result_strobe_o,
  output frfr_pkg::result_t             result_o,
  input  logic                          cfg_we_i,
  input  logic [frfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [frfr_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int SizeW = frfr_pkg::SizeW;

  // Configuration registers, stored as written.
  logic [SizeW-1:0] width_q, height_q;
  logic [1:0]       rot_q;
  logic             mirror_h_q, mirror_v_q;

  // Address stage.
  logic             s1_we_q, s1_re_q, s1_vld_q, s1_oor_q;
  logic [SizeW-1:0] s1_x_q, s1_y_q;
  logic [frfr_pkg::PixW-1:0] s1_wdata_q;

  // Result stage.
  logic s2_vld_q, s2_oor_q;

  logic             accept;
  logic [SizeW-1:0] w_eff, h_eff, out_w, out_h;
  logic [SizeW-1:0] col_ext, row_ext, sx, sy, wx, wy;
  logic             rotated, in_frame, out_rng, is_read;
  logic [frfr_pkg::PixW-1:0] rdata;
  frfr_pkg::store_req_t      st_req;

  // The store takes a request on every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= SizeW'(512);
      height_q   <= SizeW'(512);
      rot_q      <= frfr_pkg::ROT_NONE;
      mirror_h_q <= 1'b0;
      mirror_v_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        frfr_pkg::REG_FRAME_WIDTH:  width_q    <= cfg_wdata_i[SizeW-1:0];
        frfr_pkg::REG_FRAME_HEIGHT: height_q   <= cfg_wdata_i[SizeW-1:0];
        frfr_pkg::REG_ROTATION:     rot_q      <= cfg_wdata_i[1:0];
        frfr_pkg::REG_MIRROR_H:     mirror_h_q <= cfg_wdata_i[0];
        frfr_pkg::REG_MIRROR_V:     mirror_v_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Coordinate mapping. The effective frame size is the register value held
  // between one and the store dimension. An in-range read always maps to a
  // source pixel inside the effective frame, hence inside the store.
  always_comb begin
    if (width_q == '0) begin
      w_eff = SizeW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = SizeW'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = SizeW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = SizeW'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end

    rotated  = (rot_q == frfr_pkg::ROT_90) || (rot_q == frfr_pkg::ROT_270);
    out_w    = rotated ? h_eff : w_eff;
    out_h    = rotated ? w_eff : h_eff;
    col_ext  = SizeW'(req_i.col);
    row_ext  = SizeW'(req_i.row);
    is_read  = (req_i.cmd == frfr_pkg::CMD_READ);
    in_frame = (col_ext < w_eff) && (row_ext < h_eff);
    out_rng  = (col_ext >= out_w) || (row_ext >= out_h);

    // Inverse rotation first, then the mirrors.
    case (rot_q)
      frfr_pkg::ROT_90: begin
        sx = row_ext;
        sy = h_eff - SizeW'(1) - col_ext;
      end
      frfr_pkg::ROT_270: begin
        sx = w_eff - SizeW'(1) - row_ext;
        sy = col_ext;
      end
      default: begin
        sx = col_ext;
        sy = row_ext;
      end
    endcase
    wx = mirror_h_q ? (w_eff - SizeW'(1) - sx) : sx;
    wy = mirror_v_q ? (h_eff - SizeW'(1) - sy) : sy;
  end

  // Address stage: control bits are reset, the address and data are not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_we_q  <= 1'b0;
      s1_re_q  <= 1'b0;
      s1_vld_q <= 1'b0;
      s1_oor_q <= 1'b0;
    end else begin
      s1_we_q  <= accept && !is_read && in_frame;
      s1_re_q  <= accept && is_read && !out_rng;
      s1_vld_q <= accept && is_read;
      s1_oor_q <= out_rng;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q     <= is_read ? wx : col_ext;
      s1_y_q     <= is_read ? wy : row_ext;
      s1_wdata_q <= {req_i.alpha_in, req_i.red_in, req_i.green_in, req_i.blue_in};
    end
  end

  assign st_req = '{we: s1_we_q, re: s1_re_q, x: s1_x_q, y: s1_y_q, wdata: s1_wdata_q};

  frfr_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_store (
    .clk_i   (clk_i),
    .req_i   (st_req),
    .rdata_o (rdata)
  );

  // Result stage: the store delivers read data alongside these flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      s2_oor_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
      s2_oor_q <= s1_oor_q;
    end
  end

  // Stored word is A, R, G, B from high to low byte.
  assign result_strobe_o       = s2_vld_q;
  assign result_o.red_out      = s2_oor_q ? '0 : rdata[23:16];
  assign result_o.green_out    = s2_oor_q ? '0 : rdata[15:8];
  assign result_o.blue_out     = s2_oor_q ? '0 : rdata[7:0];
  assign result_o.alpha_out    = s2_oor_q ? '0 : rdata[31:24];
  assign result_o.out_of_range = s2_oor_q;

  // A result only ever follows an accepted read request.
  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(accept && (req_i.cmd == frfr_pkg::CMD_READ), 2))
    else $error("result strobe without a read request two cycles earlier");

  // A write request never produces a result.
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.cmd == frfr_pkg::CMD_WRITE)) |-> ##2 !result_strobe_o)
    else $error("write request produced a result");

  // The store port carries at most one access, and a store read always
  // belongs to an in-range read request.
  a_store_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_we_q && s1_re_q) && (!s1_re_q || (s1_vld_q && !s1_oor_q)))
    else $error("conflicting or stray store access");

endmodule
